/* hw/rtl/ppd_pkg.sv */
// Package for the periodic priority dispatcher.
// Holds item types, table entry type, state codes and fixed widths.
// No dependencies.
package ppd_pkg;

   localparam int TIME_W = 48;
   localparam int IV_W   = 16;
   localparam int PRIO_W = 8;
   localparam int TGT_W  = 2;
   localparam int SLOT_W = 4;
   localparam int STEP_W = $clog2(TIME_W);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic REPORT_DISPATCH = 1'b0;
   localparam logic REPORT_WAKE     = 1'b1;

   localparam logic [TGT_W-1:0] TARGET_NONE = 2'd2;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic [IV_W-1:0]   interval_ms;
      logic [PRIO_W-1:0] priority_req;
      logic              periodic;
      logic [TGT_W-1:0]  target;
      logic [TIME_W-1:0] first_run;
   } req_type;

   typedef struct packed {
      logic              report_kind;
      logic [SLOT_W-1:0] due_slot;
      logic [TGT_W-1:0]  due_target;
      logic [TIME_W-1:0] new_next_run;
      logic              wake_valid;
      logic [TIME_W-1:0] sleep_ms;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] next_run;
      logic [IV_W-1:0]   interval;
      logic [PRIO_W-1:0] prio;
      logic [TGT_W-1:0]  target;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DUE,
      ST_PICK,
      ST_SERVE,
      ST_DIV,
      ST_EMIT,
      ST_WAKE,
      ST_WAKE_EMIT
   } state_type;

endpackage

/* hw/rtl/ppd_rem_div.sv */
// Bit-serial remainder unit: dividend modulo divisor, one quotient bit a cycle.
// Uses ppd_pkg for widths.
module ppd_rem_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ppd_pkg::TIME_W-1:0] dividend,
   input  logic [ppd_pkg::IV_W-1:0]   divisor,
   output logic                       done,
   output logic [ppd_pkg::IV_W-1:0]   remainder
);
   import ppd_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]   dvd_ff, dvd_in;
   logic [IV_W-1:0]     rem_ff, rem_in;
   logic [IV_W-1:0]     div_ff, div_in;
   logic [IV_W:0]       shifted;
   logic [IV_W:0]       diff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[TIME_W-1]};
      diff    = shifted - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[IV_W] ? shifted[IV_W-1:0] : diff[IV_W-1:0];
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/periodic_priority_dispatcher_top.sv */
// Periodic priority dispatcher: entry table in a synchronous memory, scan sequencer.
// Uses ppd_pkg and ppd_rem_div.
//
//   channel | ports                       | moves
//   --------+-----------------------------+------------------------------------
//   req     | req_valid req_ready req_data | load or tick item (req_type)
//   rsp     | rsp_valid rsp_ready rsp_data | dispatch or wake item (rsp_type)
//
// A tick takes one due pass, then per due entry one priority pass plus a
// remainder step, then a last priority pass and a wake pass; each pass reads
// every entry from memory. Reset clears time and enable bits.
// A stalled rsp holds the sequencer at its next result; req is taken only idle.
module periodic_priority_dispatcher_top #(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ppd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ppd_pkg::rsp_type rsp_data
);
   import ppd_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [ENTRIES-1:0]  periodic_ff, periodic_in;
   logic [ENTRIES-1:0]  due_ff, due_in;

   entry_type           mem [ENTRIES];
   entry_type           rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   logic [CNT_W-1:0]    scan_cnt_ff, scan_cnt_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;

   logic                best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   entry_type           best_ff, best_in;

   logic                any_ff, any_in;
   logic [TIME_W-1:0]   min_ff, min_in;

   logic                rsp_vld_ff, rsp_vld_in;
   rsp_type             rsp_ff, rsp_in;

   logic                div_start;
   logic                div_done;
   logic [IV_W-1:0]     div_rem;
   logic [IV_W-1:0]     best_iv;
   logic [IV_W-1:0]     step;
   logic [TIME_W-1:0]   new_next;
   logic [TIME_W:0]     wake_diff;
   logic [TIME_W-1:0]   sleep;
   logic                scan_end;
   logic                take_best;
   logic                take_min;
   logic                slot_ok;
   logic                out_free;

   ppd_rem_div u_rem_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (now_ff - best_ff.next_run),
      .divisor   (best_iv),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      best_iv   = (best_ff.interval == '0) ? IV_W'(1) : best_ff.interval;
      step      = best_iv - div_rem;
      new_next  = now_ff + TIME_W'(step);
      wake_diff = {1'b0, min_ff} - {1'b0, now_ff};
      sleep     = TIME_W'(1);
      if (any_ff && !wake_diff[TIME_W] && wake_diff[TIME_W-1:0] > TIME_W'(1)) begin
         sleep = wake_diff[TIME_W-1:0];
      end
      scan_end  = rd_vld_ff && (rd_idx_ff == LAST_IDX);
      take_best = rd_vld_ff && due_ff[rd_idx_ff]
                  && (!best_vld_ff || rd_ff.prio > best_ff.prio);
      take_min  = rd_vld_ff && periodic_ff[rd_idx_ff]
                  && (!any_ff || rd_ff.next_run < min_ff);
      slot_ok   = (ENTRIES > 15) || (32'(req_data.slot) < ENTRIES);
      out_free  = !rsp_vld_ff || rsp_ready;
   end

   always_comb begin
      state_in    = state_ff;
      now_in      = now_ff;
      periodic_in = periodic_ff;
      due_in      = due_ff;
      scan_cnt_in = scan_cnt_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      best_vld_in = best_vld_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      any_in      = any_ff;
      min_in      = min_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      rsp_in      = rsp_ff;
      mem_we      = 1'b0;
      mem_waddr   = best_idx_ff;
      mem_wdata   = best_ff;
      mem_raddr   = scan_cnt_ff[IDX_W-1:0];
      div_start   = 1'b0;
      req_ready   = 1'b0;

      if (state_ff == ST_DUE || state_ff == ST_PICK || state_ff == ST_WAKE) begin
         if (scan_cnt_ff != CNT_END) begin
            rd_vld_in   = 1'b1;
            rd_idx_in   = scan_cnt_ff[IDX_W-1:0];
            scan_cnt_in = scan_cnt_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.kind == KIND_TICK) begin
                  now_in      = now_ff + 1'b1;
                  scan_cnt_in = '0;
                  state_in    = ST_DUE;
               end else if (slot_ok) begin
                  mem_we             = 1'b1;
                  mem_waddr          = IDX_W'(req_data.slot);
                  mem_wdata.next_run = req_data.first_run;
                  mem_wdata.interval = req_data.interval_ms;
                  mem_wdata.prio     = req_data.priority_req;
                  mem_wdata.target   = req_data.target;
                  periodic_in[IDX_W'(req_data.slot)] = req_data.periodic;
               end
            end
         end
         ST_DUE: begin
            if (rd_vld_ff) begin
               due_in[rd_idx_ff] = periodic_ff[rd_idx_ff] && (now_ff >= rd_ff.next_run);
            end
            if (scan_end) begin
               scan_cnt_in = '0;
               best_vld_in = 1'b0;
               state_in    = ST_PICK;
            end
         end
         ST_PICK: begin
            if (take_best) begin
               best_vld_in = 1'b1;
               best_idx_in = rd_idx_ff;
               best_in     = rd_ff;
            end
            if (scan_end) begin
               scan_cnt_in = '0;
               if (take_best || best_vld_ff) begin
                  state_in = ST_SERVE;
               end else begin
                  any_in   = 1'b0;
                  state_in = ST_WAKE;
               end
            end
         end
         ST_SERVE: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               mem_we             = 1'b1;
               mem_wdata.next_run = new_next;
               due_in[best_idx_ff] = 1'b0;
               rsp_vld_in          = 1'b1;
               rsp_in.report_kind  = REPORT_DISPATCH;
               rsp_in.due_slot     = SLOT_W'(best_idx_ff);
               rsp_in.due_target   = (best_ff.target > TARGET_NONE) ? TARGET_NONE
                                                                    : best_ff.target;
               rsp_in.new_next_run = new_next;
               rsp_in.wake_valid   = 1'b0;
               rsp_in.sleep_ms     = '0;
               rsp_in.last         = 1'b0;
               best_vld_in         = 1'b0;
               scan_cnt_in         = '0;
               state_in            = ST_PICK;
            end
         end
         ST_WAKE: begin
            if (take_min) begin
               any_in = 1'b1;
               min_in = rd_ff.next_run;
            end
            if (scan_end) begin
               state_in = ST_WAKE_EMIT;
            end
         end
         ST_WAKE_EMIT: begin
            if (out_free) begin
               rsp_vld_in          = 1'b1;
               rsp_in.report_kind  = REPORT_WAKE;
               rsp_in.due_slot     = '0;
               rsp_in.due_target   = '0;
               rsp_in.new_next_run = '0;
               rsp_in.wake_valid   = any_ff;
               rsp_in.sleep_ms     = sleep;
               rsp_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         now_ff      <= '0;
         periodic_ff <= '0;
         due_ff      <= '0;
         scan_cnt_ff <= '0;
         rd_vld_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
         any_ff      <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         now_ff      <= now_in;
         periodic_ff <= periodic_in;
         due_ff      <= due_in;
         scan_cnt_ff <= scan_cnt_in;
         rd_vld_ff   <= rd_vld_in;
         best_vld_ff <= best_vld_in;
         any_ff      <= any_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      min_ff      <= min_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* test/tb_periodic_priority_dispatcher_top.sv */
// Self-checking testbench for periodic_priority_dispatcher_top: loads and ticks
// are queued, driven over req and predicted as taken, rsp items are checked in order.
// Depends on ppd_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

module tb_periodic_priority_dispatcher_top;
   import ppd_pkg::*;

   localparam int ENTRIES = 16;
   localparam int RANDOM_ITEMS = 200;
   localparam int PHASE_ITEMS = 60;
   localparam int DRAIN_CYCLES = 1500;

   localparam logic [TGT_W-1:0] TARGET_PINNED   = 2'd0;
   localparam logic [TGT_W-1:0] TARGET_PIPE     = 2'd1;
   localparam logic [TGT_W-1:0] TARGET_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_items[$];
   rsp_type expected_reports[$];
   int      items_queued = 0;
   int      items_taken = 0;
   int      error_count = 0;
   bit      req_taken = 1'b0;

   logic [TIME_W-1:0] plan_ms = '0;

   logic [TIME_W-1:0] model_ms = '0;
   entry_type         sched_entry[ENTRIES];
   logic              entry_on[ENTRIES];

   periodic_priority_dispatcher_top #(
      .ENTRIES(ENTRIES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [TIME_W-1:0] advance_run(logic [TIME_W-1:0] next_run,
                                                     logic [IV_W-1:0] interval,
                                                     logic [TIME_W-1:0] now);
      logic [63:0] step;
      logic [63:0] nr;
      logic [63:0] nw;
      logic [63:0] result;
      step = (interval == '0) ? 64'd1 : 64'(interval);
      nr = 64'(next_run);
      nw = 64'(now);
      if (nr + step > nw) begin
         result = nr + step;
      end else begin
         result = nr + ((nw - nr) / step + 64'd1) * step;
      end
      return result[TIME_W-1:0];
   endfunction

   task automatic predict_dispatch(input req_type item);
      logic              due[ENTRIES];
      int                best;
      logic              found;
      logic [TIME_W-1:0] earliest;
      rsp_type           report;
      if (item.kind == KIND_LOAD) begin
         if (int'(item.slot) < ENTRIES) begin
            sched_entry[item.slot].next_run = item.first_run;
            sched_entry[item.slot].interval = item.interval_ms;
            sched_entry[item.slot].prio     = item.priority_req;
            sched_entry[item.slot].target   = item.target;
            entry_on[item.slot]             = item.periodic;
         end
         return;
      end
      model_ms = model_ms + 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
         due[i] = entry_on[i] && model_ms >= sched_entry[i].next_run;
      end
      for (int n = 0; n < ENTRIES; n++) begin
         best = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (due[i] && (best < 0 || sched_entry[i].prio > sched_entry[best].prio)) begin
               best = i;
            end
         end
         if (best < 0) begin
            break;
         end
         due[best] = 1'b0;
         sched_entry[best].next_run = advance_run(sched_entry[best].next_run,
                                                  sched_entry[best].interval, model_ms);
         report = '0;
         report.report_kind  = REPORT_DISPATCH;
         report.due_slot     = SLOT_W'(best);
         report.due_target   = (sched_entry[best].target == TARGET_RESERVED) ?
                               TARGET_NONE : sched_entry[best].target;
         report.new_next_run = sched_entry[best].next_run;
         expected_reports = {expected_reports, report};
      end
      found = 1'b0;
      earliest = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (entry_on[i] && (!found || sched_entry[i].next_run < earliest)) begin
            earliest = sched_entry[i].next_run;
            found = 1'b1;
         end
      end
      report = '0;
      report.report_kind = REPORT_WAKE;
      report.wake_valid  = found;
      report.sleep_ms    = 1;
      if (found && earliest > model_ms && earliest - model_ms > 1) begin
         report.sleep_ms = earliest - model_ms;
      end
      report.last = 1'b1;
      expected_reports = {expected_reports, report};
   endtask

   task automatic check_report(input rsp_type want, input rsp_type got);
      if (got.report_kind !== want.report_kind) begin
         $error("report_kind: expected %0d, got %0d", want.report_kind, got.report_kind);
         error_count++;
      end
      if (got.due_slot !== want.due_slot) begin
         $error("due_slot: expected %0d, got %0d", want.due_slot, got.due_slot);
         error_count++;
      end
      if (got.due_target !== want.due_target) begin
         $error("due_target: expected %0d, got %0d", want.due_target, got.due_target);
         error_count++;
      end
      if (got.new_next_run !== want.new_next_run) begin
         $error("new_next_run: expected %0d, got %0d", want.new_next_run, got.new_next_run);
         error_count++;
      end
      if (got.wake_valid !== want.wake_valid) begin
         $error("wake_valid: expected %0d, got %0d", want.wake_valid, got.wake_valid);
         error_count++;
      end
      if (got.sleep_ms !== want.sleep_ms) begin
         $error("sleep_ms: expected %0d, got %0d", want.sleep_ms, got.sleep_ms);
         error_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         error_count++;
      end
   endtask

   function automatic idle_mode_type current_mode();
      return idle_mode_type'((items_taken / PHASE_ITEMS) % 4);
   endfunction

   function automatic logic sender_gap();
      case (current_mode())
         IDLE_SENDER: return $urandom_range(99) < 50;
         IDLE_BOTH:   return $urandom_range(99) < 6;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stall();
      case (current_mode())
         IDLE_RECEIVER: return $urandom_range(99) < 50;
         IDLE_BOTH:     return $urandom_range(99) < 6;
         default:       return 1'b0;
      endcase
   endfunction

   always @(negedge clock) begin
      logic keep_item;
      keep_item = req_valid && !req_taken;
      req_taken = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!keep_item) begin
         if (pending_items.size() > 0 && !sender_gap()) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !receiver_stall();
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected item: kind %0d slot %0d", rsp_data.report_kind,
                      rsp_data.due_slot);
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               check_report(want, rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            predict_dispatch(req_data);
            items_taken++;
            req_taken = 1'b1;
         end
      end
   end

   task automatic add_load(input logic [SLOT_W-1:0] slot, input logic [IV_W-1:0] interval,
                           input logic [PRIO_W-1:0] prio, input logic periodic,
                           input logic [TGT_W-1:0] target, input logic [TIME_W-1:0] first_run);
      req_type item;
      item.kind         = KIND_LOAD;
      item.slot         = slot;
      item.interval_ms  = interval;
      item.priority_req = prio;
      item.periodic     = periodic;
      item.target       = target;
      item.first_run    = first_run;
      pending_items = {pending_items, item};
      items_queued++;
   endtask

   task automatic add_tick(input req_type filler);
      req_type item;
      item = filler;
      item.kind = KIND_TICK;
      pending_items = {pending_items, item};
      items_queued++;
      plan_ms = plan_ms + 1'b1;
   endtask

   function automatic logic [TIME_W-1:0] random_first_run();
      logic [TIME_W-1:0] back;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return plan_ms + TIME_W'($urandom_range(10));
      end else if (pick < 75) begin
         back = TIME_W'($urandom_range(40));
         return (plan_ms >= back) ? plan_ms - back : '0;
      end
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [IV_W-1:0] random_interval();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return IV_W'($urandom_range(1, 8));
      end else if (pick < 70) begin
         return '0;
      end
      return IV_W'($urandom);
   endfunction

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         sched_entry[i] = '0;
         entry_on[i] = 1'b0;
      end

      add_tick('1);
      add_load(4'd0, 16'd0, 8'd255, 1'b1, TARGET_PINNED, 48'd2);
      add_load(4'd15, 16'hFFFF, 8'd0, 1'b1, TARGET_RESERVED, 48'hFFFF_FFFF_FFFF);
      add_load(4'd5, 16'd3, 8'd255, 1'b1, TARGET_PIPE, 48'd0);
      add_load(4'd7, 16'd1, 8'hAA, 1'b0, TARGET_PINNED, 48'd0);
      add_load(4'd9, 16'd5, 8'd128, 1'b1, TARGET_NONE, 48'd4);
      add_load(4'd12, 16'd2, 8'd128, 1'b1, TARGET_RESERVED, 48'd3);
      repeat (5) add_tick('0);
      add_load(4'd3, 16'd2, 8'd1, 1'b1, TARGET_PIPE, 48'd0);
      add_load(4'd0, 16'd1, 8'd255, 1'b0, TARGET_PINNED, 48'd0);
      add_load(4'd10, 16'd7, 8'd64, 1'b1, TARGET_PINNED, 48'h8000_0000_0000);
      repeat (5) add_tick('0);
      add_load(4'd15, 16'hFFFF, 8'd255, 1'b1, TARGET_PIPE, 48'd0);
      repeat (2) add_tick('0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(99) < 30) begin
            add_load(SLOT_W'($urandom), random_interval(),
                     ($urandom_range(1) != 0) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom),
                     $urandom_range(99) < 80, TGT_W'($urandom_range(3)), random_first_run());
         end else begin
            add_tick(req_type'(80'({$urandom, $urandom, $urandom})));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_taken < items_queued || expected_reports.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (expected_reports.size() > 0) begin
            $error("%0d expected items never arrived", expected_reports.size());
         end
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $error("timeout with %0d of %0d items taken", items_taken, items_queued);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_rem_div.sv
hw/rtl/periodic_priority_dispatcher_top.sv
test/tb_periodic_priority_dispatcher_top.sv
